FILE: rtl/core/divider_timer_with_reload_top_defines.svh
// Assertion macros for the divider timer block.
`ifndef DIVIDER_TIMER_WITH_RELOAD_TOP_DEFINES_SVH
`define DIVIDER_TIMER_WITH_RELOAD_TOP_DEFINES_SVH

// Same-cycle implication.
`define DTR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DTR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dtr_pkg.sv
`default_nettype none
package dtr_pkg;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	localparam logic [1:0] REG_DIV  = 2'd0;
	localparam logic [1:0] REG_TIMA = 2'd1;
	localparam logic [1:0] REG_TMA  = 2'd2;
	localparam logic [1:0] REG_TAC  = 2'd3;

	localparam logic [7:0] CNT_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] reg_sel;
		logic [7:0] write_data;
		logic [7:0] tick_count;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} res_item_t;

	// log2 of the counter period in machine cycles: 256, 4, 16, 64
	function automatic logic [3:0] period_shift(input logic [1:0] sel);
		logic [3:0] sh;
		case (sel)
			2'd0: sh = 4'd8;
			2'd1: sh = 4'd2;
			2'd2: sh = 4'd4;
			default: sh = 4'd6;
		endcase
		return sh;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dtr_in_reg.sv
`default_nettype none
module dtr_in_reg
	import dtr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	input  wire cmd_item_t cmd,
	output logic           cmd_stall,
	input  wire logic      advance,
	output logic           valid_s1,
	output cmd_item_t      item_s1
);

	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			item_s1 <= cmd;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/dtr_timer.sv
`default_nettype none
module dtr_timer
	import dtr_pkg::*;
#(
	parameter logic [15:0] DIV_RESET = 16'd43980
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire cmd_item_t item,
	output res_item_t      result
);

	logic [15:0] div_q, div_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  mod_q, mod_d;
	logic [2:0]  ctrl_q, ctrl_d;
	logic        pend_q, pend_d;

	logic [16:0] sum;
	logic [16:0] crossed;
	logic [3:0]  sh;

	assign sum     = {1'b0, div_q} + {9'b0, item.tick_count};
	assign sh      = period_shift(ctrl_q[1:0]);
	assign crossed = (sum >> sh) - ({1'b0, div_q} >> sh);

	always_comb begin
		div_d  = div_q;
		cnt_d  = cnt_q;
		mod_d  = mod_q;
		ctrl_d = ctrl_q;
		pend_d = pend_q;
		result = '0;
		unique case (item.action)
			ACT_TICK: begin
				div_d = sum[15:0];
				if (pend_q) begin
					pend_d           = 1'b0;
					result.timer_irq = 1'b1;
					cnt_d            = mod_q;
				end
				if (crossed != 17'd0 && ctrl_q[2]) begin
					if (cnt_d == CNT_MAX) begin
						cnt_d  = 8'd0;
						pend_d = 1'b1;
					end else begin
						cnt_d = cnt_d + crossed[7:0];
					end
				end
			end
			ACT_READ: begin
				unique case (item.reg_sel)
					REG_DIV:  result.read_data = div_q[15:8];
					REG_TIMA: result.read_data = cnt_q;
					REG_TMA:  result.read_data = mod_q;
					default:  result.read_data = {5'd0, ctrl_q};
				endcase
			end
			ACT_WRITE: begin
				unique case (item.reg_sel)
					REG_DIV:  div_d  = 16'd0;
					REG_TIMA: cnt_d  = item.write_data;
					REG_TMA:  mod_d  = item.write_data;
					default:  ctrl_d = item.write_data[2:0];
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= DIV_RESET;
			cnt_q  <= 8'd0;
			mod_q  <= 8'd0;
			ctrl_q <= 3'd0;
			pend_q <= 1'b0;
		end else if (fire) begin
			div_q  <= div_d;
			cnt_q  <= cnt_d;
			mod_q  <= mod_d;
			ctrl_q <= ctrl_d;
			pend_q <= pend_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/divider_timer_with_reload_top.sv
// A command passes the input register, then the result register.
// Throughput: one command per cycle unless res_stall holds the result;
// the timer state update is a single registered step between the two.
// Reset: divider loads DIV_RESET, counter, modulo, control and the pending
// overflow clear, both pipeline registers empty.
`default_nettype none
`include "divider_timer_with_reload_top_defines.svh"
module divider_timer_with_reload_top
	import dtr_pkg::*;
#(
	parameter logic [15:0] DIV_RESET = 16'd43980
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res
);

	logic      advance;
	logic      valid_s1;
	logic      fire;
	cmd_item_t item_s1;
	res_item_t result;

	assign advance = !res_valid || !res_stall;
	assign fire    = valid_s1 && advance;

	dtr_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	dtr_timer #(
		.DIV_RESET (DIV_RESET)
	) u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res <= result;
		end
	end

	`DTR_ASSERT_IMP(a_stall_only_when_blocked, clk, arst_n, cmd_stall,
		res_valid && res_stall && valid_s1, "command stalled without a blocked result")
	`DTR_ASSERT_NXT(a_fire_gives_result, clk, arst_n, fire, res_valid,
		"command left the input register without a result")
	`DTR_ASSERT_IMP(a_irq_no_data, clk, arst_n, res_valid && res.timer_irq,
		res.read_data == 8'd0, "interrupt result carries read data")

endmodule
`default_nettype wire

FILE: tb/sv/tb_divider_timer_with_reload_top.sv
`default_nettype none
module tb_divider_timer_with_reload_top;
	import dtr_pkg::*;

	localparam logic [15:0] DIV_INIT = 16'd43980;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1450;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_item_t cmd;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res;

	divider_timer_with_reload_top #(
		.DIV_RESET(DIV_INIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// predicted timer state
	logic [15:0] div_q;
	logic [7:0] tima_q;
	logic [7:0] tma_q;
	logic [2:0] tac_q;
	logic ovf_pending_q;

	res_item_t expected_results[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	res_item_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 100)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic reset_timer_model();
		div_q = DIV_INIT;
		tima_q = 8'd0;
		tma_q = 8'd0;
		tac_q = 3'd0;
		ovf_pending_q = 1'b0;
	endtask

	function automatic res_item_t timer_model_step(input cmd_item_t c);
		res_item_t r;
		logic [16:0] total;
		logic [16:0] old_div;
		logic [16:0] crossed;
		int unsigned sh;
		r = '0;
		case (c.action)
			ACT_TICK: begin
				old_div = {1'b0, div_q};
				total = old_div + {9'd0, c.tick_count};
				div_q = total[15:0];
				if (ovf_pending_q) begin
					ovf_pending_q = 1'b0;
					r.timer_irq = 1'b1;
					tima_q = tma_q;
				end
				case (tac_q[1:0])
					2'd0: sh = 8;
					2'd1: sh = 2;
					2'd2: sh = 4;
					default: sh = 6;
				endcase
				crossed = (total >> sh) - (old_div >> sh);
				if (crossed != 17'd0 && tac_q[2]) begin
					if (tima_q == CNT_MAX) begin
						tima_q = 8'd0;
						ovf_pending_q = 1'b1;
					end else begin
						tima_q = tima_q + crossed[7:0];
					end
				end
			end
			ACT_READ: begin
				case (c.reg_sel)
					REG_DIV: r.read_data = div_q[15:8];
					REG_TIMA: r.read_data = tima_q;
					REG_TMA: r.read_data = tma_q;
					default: r.read_data = {5'd0, tac_q};
				endcase
			end
			ACT_WRITE: begin
				case (c.reg_sel)
					REG_DIV: div_q = 16'd0;
					REG_TIMA: tima_q = c.write_data;
					REG_TMA: tma_q = c.write_data;
					default: tac_q = c.write_data[2:0];
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_item_t make_cmd(input logic [1:0] act, input logic [1:0] sel,
			input logic [7:0] wdata, input logic [7:0] ticks);
		cmd_item_t c;
		c.action = act;
		c.reg_sel = sel;
		c.write_data = wdata;
		c.tick_count = ticks;
		return c;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_cmd(input cmd_item_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		expected_results.push_back(timer_model_step(c));
		burst_left--;
		@(negedge clk);
	endtask

	task automatic test_reset_values();
		send_cmd(make_cmd(ACT_READ, REG_DIV, 8'h00, 8'h00));
		send_cmd(make_cmd(ACT_READ, REG_TIMA, 8'h00, 8'h00));
		send_cmd(make_cmd(ACT_READ, REG_TMA, 8'h00, 8'h00));
		send_cmd(make_cmd(ACT_READ, REG_TAC, 8'h00, 8'h00));
	endtask

	task automatic test_register_access();
		send_cmd(make_cmd(ACT_WRITE, REG_TMA, 8'hFF, 8'h00));
		send_cmd(make_cmd(ACT_READ, REG_TMA, 8'h00, 8'hFF));
		send_cmd(make_cmd(ACT_WRITE, REG_TAC, 8'hFF, 8'hFF));
		send_cmd(make_cmd(ACT_READ, REG_TAC, 8'hFF, 8'h00));
		send_cmd(make_cmd(ACT_WRITE, REG_TIMA, 8'h00, 8'h00));
		send_cmd(make_cmd(ACT_WRITE, REG_DIV, 8'hFF, 8'hFF));
		send_cmd(make_cmd(ACT_READ, REG_DIV, 8'h00, 8'h00));
		send_cmd(make_cmd(ACT_TICK, REG_TAC, 8'h00, 8'hFF));
		send_cmd(make_cmd(ACT_READ, REG_TIMA, 8'h00, 8'h00));
	endtask

	task automatic test_counter_overflow();
		send_cmd(make_cmd(ACT_WRITE, REG_TAC, 8'h05, 8'h00));
		send_cmd(make_cmd(ACT_WRITE, REG_TMA, 8'h80, 8'h00));
		send_cmd(make_cmd(ACT_WRITE, REG_TIMA, 8'hFE, 8'h00));
		send_cmd(make_cmd(ACT_TICK, REG_DIV, 8'h00, 8'h04));
		send_cmd(make_cmd(ACT_TICK, REG_DIV, 8'h00, 8'hFF));
		// zero-length batch still services the pending overflow
		send_cmd(make_cmd(ACT_TICK, REG_DIV, 8'h00, 8'h00));
		send_cmd(make_cmd(ACT_READ, REG_TIMA, 8'h00, 8'h00));
		// reload to 0xFF followed by another overflow in the same batch
		send_cmd(make_cmd(ACT_WRITE, REG_TMA, 8'hFF, 8'h00));
		send_cmd(make_cmd(ACT_WRITE, REG_TIMA, 8'hFF, 8'h00));
		send_cmd(make_cmd(ACT_TICK, REG_DIV, 8'h00, 8'h08));
		send_cmd(make_cmd(ACT_TICK, REG_DIV, 8'h00, 8'h08));
		send_cmd(make_cmd(ACT_TICK, REG_DIV, 8'h00, 8'h00));
	endtask

	task automatic test_unused_action();
		send_cmd(make_cmd(ACT_UNUSED, REG_TIMA, 8'hA5, 8'h5A));
		send_cmd(make_cmd(ACT_READ, REG_TIMA, 8'h00, 8'h00));
	endtask

	task automatic test_random_traffic();
		int done;
		int pick;
		logic [7:0] ticks;
		logic [7:0] wdata;
		cmd_item_t c;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			wdata = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 3))
				0: ticks = 8'($urandom_range(0, 7));
				1: ticks = 8'($urandom_range(248, 255));
				default: ticks = 8'($urandom_range(0, 255));
			endcase
			c = make_cmd(ACT_TICK, 2'($urandom_range(0, 3)), wdata, ticks);
			if (pick >= 60 && pick < 75) begin
				c.action = ACT_READ;
			end else if (pick >= 75 && pick < 80) begin
				c.action = ACT_WRITE;
				c.reg_sel = REG_TIMA;
				if ($urandom_range(0, 1) == 0)
					c.write_data = 8'($urandom_range(240, 255));
			end else if (pick >= 80 && pick < 84) begin
				c.action = ACT_WRITE;
				c.reg_sel = REG_TMA;
			end else if (pick >= 84 && pick < 89) begin
				c.action = ACT_WRITE;
				c.reg_sel = REG_TAC;
				if ($urandom_range(0, 9) < 7)
					c.write_data[2] = 1'b1;
			end else if (pick == 89) begin
				c.action = ACT_WRITE;
				c.reg_sel = REG_DIV;
			end else if (pick >= 90 && pick < 93) begin
				c.action = ACT_UNUSED;
			end
			send_cmd(c);
			if (c.action != ACT_UNUSED)
				done++;
		end
	endtask

	// receiver stall pattern, switching mode every so often
	int stall_mode = 0;
	int stall_phase = 0;
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_phase = $urandom_range(16, 96);
		end
		stall_phase--;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 1) == 0);
			2: res_stall <= ($urandom_range(0, 3) == 0);
			default: res_stall <= (stall_phase % 8) < 3;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result transfer with nothing expected: rd=%02h irq=%0b",
					res.read_data, res.timer_irq));
			end else begin
				want = expected_results.pop_front();
				if (res.read_data !== want.read_data)
					report_mismatch($sformatf("read_data got %02h want %02h",
						res.read_data, want.read_data));
				if (res.timer_irq !== want.timer_irq)
					report_mismatch($sformatf("timer_irq got %0b want %0b",
						res.timer_irq, want.timer_irq));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer in %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		reset_timer_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_values();
		test_register_access();
		test_counter_overflow();
		test_unused_action();
		test_random_traffic();
		cmd_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
